// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the map.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define E2F_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define E2F_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
	`E2F_ASSERT(lbl, clk, rstn, !(cond), msg)

`endif

// ===== rtl/e2f_pkg.sv =====
// Shared constants, types and CORDIC angle table of the equirect-to-fisheye map.
package e2f_pkg;

	localparam int PIX_FRAC     = 16;
	localparam int VEC_FRAC     = 20;
	localparam int CORDIC_STEPS = 16;
	localparam int ANG_W        = 27;
	localparam int AQ_W         = 25;
	localparam int VW           = 24;
	localparam int XW           = 32;
	localparam int TH2_W        = 24;
	localparam int RQ_W         = 29;
	localparam int DIM_W        = 13;
	localparam int FOV_W        = 9;
	localparam int R2_W         = 14;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 14;

	localparam int INV_GAIN     = 636751;
	localparam int THETA_SCALE  = 180 * 65536;
	localparam int PHI_SCALE    = 360 * 65536;

	typedef logic signed [ANG_W-1:0] ang_t;

	localparam ang_t DEG90  = ang_t'(90 * 65536);
	localparam ang_t DEG180 = ang_t'(180 * 65536);
	localparam ang_t TURN   = ang_t'(360 * 65536);

	localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TGT_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TGT_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FOV_DEG    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_X2  = 3'd5;

	localparam logic [DIM_W-1:0] RST_SRC_WIDTH  = 13'd1920;
	localparam logic [DIM_W-1:0] RST_SRC_HEIGHT = 13'd1080;
	localparam logic [DIM_W-1:0] RST_TGT_WIDTH  = 13'd960;
	localparam logic [DIM_W-1:0] RST_TGT_HEIGHT = 13'd1080;
	localparam logic [FOV_W-1:0] RST_FOV_DEG    = 9'd180;
	localparam logic [R2_W-1:0]  RST_RADIUS_X2  = 14'd1080;

	function automatic ang_t atan_q16(input int k);
		ang_t a;
		case (k)
			0:       a = ang_t'(2949120);
			1:       a = ang_t'(1740967);
			2:       a = ang_t'(919879);
			3:       a = ang_t'(466945);
			4:       a = ang_t'(234379);
			5:       a = ang_t'(117304);
			6:       a = ang_t'(58666);
			7:       a = ang_t'(29335);
			8:       a = ang_t'(14668);
			9:       a = ang_t'(7334);
			10:      a = ang_t'(3667);
			11:      a = ang_t'(1833);
			12:      a = ang_t'(917);
			13:      a = ang_t'(458);
			14:      a = ang_t'(229);
			15:      a = ang_t'(115);
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

// ===== rtl/e2f_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a side payload.
module e2f_div #(
	parameter int NUM_W = 36,
	parameter int DEN_W = 13,
	parameter int Q_W   = 25,
	parameter int PAY_W = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic [PAY_W-1:0] in_pay,
	output logic             out_valid,
	output logic [Q_W-1:0]   quot,
	output logic [DEN_W-1:0] rem,
	output logic [PAY_W-1:0] out_pay
);

	localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

	logic             val_s [Q_W];
	logic [CW-1:0]    rem_s [Q_W];
	logic [Q_W-1:0]   quo_s [Q_W];
	logic [PAY_W-1:0] pay_s [Q_W];

	for (genvar i = 0; i < Q_W; i++) begin : g_stage
		localparam int B = Q_W - 1 - i;
		logic          v_in;
		logic [CW-1:0] r_in;
		logic [Q_W-1:0] q_in;
		logic [PAY_W-1:0] p_in;
		logic [CW-1:0] dsh;
		logic          ge;

		if (i == 0) begin : g_first
			assign v_in = in_valid;
			assign r_in = CW'(num);
			assign q_in = '0;
			assign p_in = in_pay;
		end else begin : g_next
			assign v_in = val_s[i-1];
			assign r_in = rem_s[i-1];
			assign q_in = quo_s[i-1];
			assign p_in = pay_s[i-1];
		end

		assign dsh = CW'(den) << B;
		assign ge  = (r_in >= dsh);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				val_s[i] <= 1'b0;
			end else if (adv) begin
				val_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[i] <= ge ? (r_in - dsh) : r_in;
				quo_s[i] <= q_in | (Q_W'(ge) << B);
				pay_s[i] <= p_in;
			end
		end
	end

	assign out_valid = val_s[Q_W-1];
	assign quot      = quo_s[Q_W-1];
	assign rem       = rem_s[Q_W-1][DEN_W-1:0];
	assign out_pay   = pay_s[Q_W-1];

endmodule

// ===== rtl/e2f_rot.sv =====
// Pipelined CORDIC rotation: angle wrap and fold stage, then sixteen micro-rotations.
module e2f_rot #(
	parameter int W     = 24,
	parameter int PAY_W = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 in_valid,
	input  logic signed [W-1:0]  x_in,
	input  logic signed [W-1:0]  y_in,
	input  e2f_pkg::ang_t        z_in,
	input  logic [PAY_W-1:0]     in_pay,
	output logic                 out_valid,
	output logic signed [W-1:0]  x_out,
	output logic signed [W-1:0]  y_out,
	output logic [PAY_W-1:0]     out_pay
);

	import e2f_pkg::*;

	localparam int N = CORDIC_STEPS + 1;

	logic                val_s [N];
	logic signed [W-1:0] x_s   [N];
	logic signed [W-1:0] y_s   [N];
	ang_t                z_s   [N];
	logic [PAY_W-1:0]    pay_s [N];

	ang_t zw;
	ang_t zf;
	logic neg;

	always_comb begin
		zw = z_in;
		if (zw > DEG180) zw = zw - TURN;
		if (zw <= -DEG180) zw = zw + TURN;
		zf  = zw;
		neg = 1'b0;
		if (zw > DEG90) begin
			zf  = zw - DEG180;
			neg = 1'b1;
		end else if (zw < -DEG90) begin
			zf  = zw + DEG180;
			neg = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s[0] <= 1'b0;
		end else if (adv) begin
			val_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s[0]   <= neg ? -x_in : x_in;
			y_s[0]   <= neg ? -y_in : y_in;
			z_s[0]   <= zf;
			pay_s[0] <= in_pay;
		end
	end

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				val_s[k+1] <= 1'b0;
			end else if (adv) begin
				val_s[k+1] <= val_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (z_s[k] >= 0) begin
					x_s[k+1] <= x_s[k] - (y_s[k] >>> k);
					y_s[k+1] <= y_s[k] + (x_s[k] >>> k);
					z_s[k+1] <= z_s[k] - atan_q16(k);
				end else begin
					x_s[k+1] <= x_s[k] + (y_s[k] >>> k);
					y_s[k+1] <= y_s[k] - (x_s[k] >>> k);
					z_s[k+1] <= z_s[k] + atan_q16(k);
				end
				pay_s[k+1] <= pay_s[k];
			end
		end
	end

	assign out_valid = val_s[N-1];
	assign x_out     = x_s[N-1];
	assign y_out     = y_s[N-1];
	assign out_pay   = pay_s[N-1];

endmodule

// ===== rtl/e2f_vec.sv =====
// Pipelined CORDIC vectoring: half-plane stage, then sixteen steps giving angle and magnitude.
module e2f_vec #(
	parameter int W     = 24,
	parameter int PAY_W = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 in_valid,
	input  logic signed [W-1:0]  x_in,
	input  logic signed [W-1:0]  y_in,
	input  logic [PAY_W-1:0]     in_pay,
	output logic                 out_valid,
	output e2f_pkg::ang_t        ang,
	output logic signed [W-1:0]  mag,
	output logic [PAY_W-1:0]     out_pay
);

	import e2f_pkg::*;

	localparam int N = CORDIC_STEPS + 1;

	logic                val_s  [N];
	logic                zero_s [N];
	logic signed [W-1:0] x_s    [N];
	logic signed [W-1:0] y_s    [N];
	ang_t                z_s    [N];
	logic [PAY_W-1:0]    pay_s  [N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s[0] <= 1'b0;
		end else if (adv) begin
			val_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			zero_s[0] <= (x_in == '0) && (y_in == '0);
			if (x_in < 0) begin
				x_s[0] <= -x_in;
				y_s[0] <= -y_in;
				z_s[0] <= (y_in >= 0) ? DEG180 : -DEG180;
			end else begin
				x_s[0] <= x_in;
				y_s[0] <= y_in;
				z_s[0] <= '0;
			end
			pay_s[0] <= in_pay;
		end
	end

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				val_s[k+1] <= 1'b0;
			end else if (adv) begin
				val_s[k+1] <= val_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (y_s[k] >= 0) begin
					x_s[k+1] <= x_s[k] + (y_s[k] >>> k);
					y_s[k+1] <= y_s[k] - (x_s[k] >>> k);
					z_s[k+1] <= z_s[k] + atan_q16(k);
				end else begin
					x_s[k+1] <= x_s[k] - (y_s[k] >>> k);
					y_s[k+1] <= y_s[k] + (x_s[k] >>> k);
					z_s[k+1] <= z_s[k] - atan_q16(k);
				end
				zero_s[k+1] <= zero_s[k];
				pay_s[k+1]  <= pay_s[k];
			end
		end
	end

	assign out_valid = val_s[N-1];
	assign ang       = zero_s[N-1] ? '0 : z_s[N-1];
	assign mag       = zero_s[N-1] ? '0 : x_s[N-1];
	assign out_pay   = pay_s[N-1];

endmodule

// ===== rtl/equirect_to_fisheye_map.sv =====
// Equirectangular-to-fisheye coordinate map, top level.
// One output pixel position enters per clock and one source coordinate leaves per clock;
// each item passes through the two modulo dividers (COORD_BITS stages), the angle
// dividers (25 stages), the radius divider (29 stages) and five 17-stage CORDIC units
// in four ranks, all of which advance together and halt as one while a result waits
// at the output. Writes to the configuration port are applied at once, so they belong
// only to an idle pipeline.
// Results carry FRAC_BITS fractional bits; out-of-range points come out as zero with
// in_range low.
`include "assert_macros.svh"

module equirect_to_fisheye_map #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 8,
	localparam int OUT_W     = COORD_BITS + FRAC_BITS,
	localparam int IN_TW     = ((2 * COORD_BITS + 7) / 8) * 8,
	localparam int OUT_TW    = ((2 * OUT_W + 7) / 8) * 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wen,
	input  logic [e2f_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [e2f_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [IN_TW-1:0]                   s_tdata,  // out_col, out_row
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [OUT_TW-1:0]                  m_tdata,  // src_x, src_y
	output logic [0:0]                         m_tuser   // in_range
);

	import e2f_pkg::*;

	localparam int TN_W = COORD_BITS + 24;
	localparam int PN_W = COORD_BITS + 25;
	localparam int RN_W = R2_W + TH2_W;
	localparam int UW   = 34;
	localparam logic signed [UW-1:0] CLIM = UW'(64'd1 << (COORD_BITS + PIX_FRAC));

	// configuration registers
	logic [DIM_W-1:0] src_w_q, src_h_q, tgt_w_q, tgt_h_q;
	logic [FOV_W-1:0] fov_q;
	logic [R2_W-1:0]  r2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= RST_SRC_WIDTH;
			src_h_q <= RST_SRC_HEIGHT;
			tgt_w_q <= RST_TGT_WIDTH;
			tgt_h_q <= RST_TGT_HEIGHT;
			fov_q   <= RST_FOV_DEG;
			r2_q    <= RST_RADIUS_X2;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_SRC_WIDTH:  src_w_q <= cfg_wdata[DIM_W-1:0];
				CFG_SRC_HEIGHT: src_h_q <= cfg_wdata[DIM_W-1:0];
				CFG_TGT_WIDTH:  tgt_w_q <= cfg_wdata[DIM_W-1:0];
				CFG_TGT_HEIGHT: tgt_h_q <= cfg_wdata[DIM_W-1:0];
				CFG_FOV_DEG:    fov_q   <= cfg_wdata[FOV_W-1:0];
				CFG_RADIUS_X2:  r2_q    <= cfg_wdata[R2_W-1:0];
				default: ;
			endcase
		end
	end

	logic adv;
	logic valid_s9;

	assign adv      = m_tready || !valid_s9;
	assign s_tready = adv;

	logic [COORD_BITS-1:0] in_col, in_row;
	assign in_col = s_tdata[COORD_BITS-1:0];
	assign in_row = s_tdata[2*COORD_BITS-1:COORD_BITS];

	// reduce row modulo twice the target height and column modulo the target width
	logic            mod_valid;
	logic [R2_W-1:0] row_rem;
	logic [DIM_W-1:0] col_rem;

	e2f_div #(.NUM_W(COORD_BITS), .DEN_W(R2_W), .Q_W(COORD_BITS), .PAY_W(1)) u_mod_row (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(s_tvalid),
		.num(in_row), .den({tgt_h_q, 1'b0}), .in_pay(1'b0),
		.out_valid(mod_valid), .quot(), .rem(row_rem), .out_pay()
	);

	e2f_div #(.NUM_W(COORD_BITS), .DEN_W(DIM_W), .Q_W(COORD_BITS), .PAY_W(1)) u_mod_col (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(s_tvalid),
		.num(in_col), .den(tgt_w_q), .in_pay(1'b0),
		.out_valid(), .quot(), .rem(col_rem), .out_pay()
	);

	// scale to angle numerators
	logic            valid_s2;
	logic [TN_W-1:0] th_num_s2;
	logic [PN_W-1:0] ph_num_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= mod_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			th_num_s2 <= TN_W'(COORD_BITS'(row_rem)) * TN_W'(THETA_SCALE);
			ph_num_s2 <= PN_W'(COORD_BITS'(col_rem)) * PN_W'(PHI_SCALE);
		end
	end

	logic            adiv_valid;
	logic [AQ_W-1:0] th_quot, ph_quot;

	e2f_div #(.NUM_W(TN_W), .DEN_W(DIM_W), .Q_W(AQ_W), .PAY_W(1)) u_div_th (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(valid_s2),
		.num(th_num_s2), .den(tgt_h_q), .in_pay(1'b0),
		.out_valid(adiv_valid), .quot(th_quot), .rem(), .out_pay()
	);

	e2f_div #(.NUM_W(PN_W), .DEN_W(DIM_W), .Q_W(AQ_W), .PAY_W(1)) u_div_ph (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(valid_s2),
		.num(ph_num_s2), .den(tgt_w_q), .in_pay(1'b0),
		.out_valid(), .quot(ph_quot), .rem(), .out_pay()
	);

	// wrap angles into the half-open turn
	logic valid_s3;
	ang_t th1_s3, ph1_s3;
	ang_t thq_e, phq_n;

	assign thq_e = ang_t'(th_quot);
	assign phq_n = -ang_t'(ph_quot);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= adiv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			th1_s3 <= (thq_e > DEG180) ? thq_e - TURN : thq_e;
			ph1_s3 <= (phq_n <= -DEG180) ? phq_n + TURN : phq_n;
		end
	end

	// sine and cosine of both angles
	logic                 trig_valid;
	logic signed [VW-1:0] ct, st, cf, sf;

	e2f_rot #(.W(VW), .PAY_W(1)) u_rot_th (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(valid_s3),
		.x_in(VW'(INV_GAIN)), .y_in('0), .z_in(th1_s3), .in_pay(1'b0),
		.out_valid(trig_valid), .x_out(ct), .y_out(st), .out_pay()
	);

	e2f_rot #(.W(VW), .PAY_W(1)) u_rot_ph (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(valid_s3),
		.x_in(VW'(INV_GAIN)), .y_in('0), .z_in(ph1_s3), .in_pay(1'b0),
		.out_valid(), .x_out(cf), .y_out(sf), .out_pay()
	);

	// unit vector
	logic                   valid_s4;
	logic signed [VW-1:0]   x1_s4, y1_s4, z1_s4;
	logic signed [2*VW-1:0] p_xc, p_ys;

	assign p_xc = st * cf;
	assign p_ys = st * sf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s4 <= trig_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x1_s4 <= p_xc[VEC_FRAC +: VW];
			y1_s4 <= p_ys[VEC_FRAC +: VW];
			z1_s4 <= ct;
		end
	end

	// azimuth of the turned vector
	logic                 vec1_valid;
	ang_t                 ph2_v1;
	logic signed [VW-1:0] mag1;
	logic [VW-1:0]        x1_v1;

	e2f_vec #(.W(VW), .PAY_W(VW)) u_vec_ph (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(valid_s4),
		.x_in(z1_s4), .y_in(y1_s4), .in_pay(x1_s4),
		.out_valid(vec1_valid), .ang(ph2_v1), .mag(mag1), .out_pay(x1_v1)
	);

	logic                   valid_s5;
	logic signed [VW-1:0]   nx_s5, rho_s5;
	ang_t                   ph2_s5;
	logic signed [2*VW-1:0] p_rho;

	assign p_rho = mag1 * VW'(INV_GAIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s5 <= vec1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nx_s5  <= -$signed(x1_v1);
			rho_s5 <= p_rho[VEC_FRAC +: VW];
			ph2_s5 <= ph2_v1;
		end
	end

	// polar angle of the turned vector
	logic             vec2_valid;
	ang_t             th2_raw;
	logic [ANG_W-1:0] ph2_v2;

	e2f_vec #(.W(VW), .PAY_W(ANG_W)) u_vec_th (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(valid_s5),
		.x_in(nx_s5), .y_in(rho_s5), .in_pay(ph2_s5),
		.out_valid(vec2_valid), .ang(th2_raw), .mag(), .out_pay(ph2_v2)
	);

	// clamp and field-of-view test
	logic             valid_s6, ok_s6;
	logic [TH2_W-1:0] th2_s6;
	ang_t             ph2_s6;
	ang_t             th2_c;

	always_comb begin
		th2_c = th2_raw;
		if (th2_raw < 0) th2_c = '0;
		if (th2_raw > DEG180) th2_c = DEG180;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (adv) begin
			valid_s6 <= vec2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			th2_s6 <= th2_c[TH2_W-1:0];
			ok_s6  <= ({th2_c[TH2_W-1:0], 1'b0} <= {fov_q, 16'h0000});
			ph2_s6 <= $signed(ph2_v2);
		end
	end

	logic            valid_s7, ok_s7;
	logic [RN_W-1:0] rnum_s7;
	ang_t            ph2_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else if (adv) begin
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rnum_s7 <= RN_W'(r2_q) * RN_W'(th2_s6);
			ok_s7   <= ok_s6;
			ph2_s7  <= ph2_s6;
		end
	end

	// fisheye radius
	logic             rdiv_valid;
	logic [RQ_W-1:0]  r_quot;
	logic [ANG_W:0]   r_pay;

	e2f_div #(.NUM_W(RN_W), .DEN_W(FOV_W), .Q_W(RQ_W), .PAY_W(ANG_W + 1)) u_div_r (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(valid_s7),
		.num(rnum_s7), .den(fov_q), .in_pay({ok_s7, ph2_s7}),
		.out_valid(rdiv_valid), .quot(r_quot), .rem(), .out_pay(r_pay)
	);

	logic                        valid_s8, ok_s8;
	logic signed [XW-1:0]        x0_s8;
	ang_t                        ph2_s8;
	logic [RQ_W+VEC_FRAC-1:0]    p_x0;

	assign p_x0 = (RQ_W + VEC_FRAC)'(r_quot) * (RQ_W + VEC_FRAC)'(INV_GAIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8 <= 1'b0;
		end else if (adv) begin
			valid_s8 <= rdiv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x0_s8  <= XW'(p_x0[VEC_FRAC +: RQ_W]);
			ok_s8  <= r_pay[ANG_W];
			ph2_s8 <= $signed(r_pay[ANG_W-1:0]);
		end
	end

	// place on the image circle
	logic                 pos_valid;
	logic signed [XW-1:0] dx, dy;
	logic                 ok_pos;

	e2f_rot #(.W(XW), .PAY_W(1)) u_rot_pos (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(valid_s8),
		.x_in(x0_s8), .y_in('0), .z_in(ph2_s8), .in_pay(ok_s8),
		.out_valid(pos_valid), .x_out(dx), .y_out(dy), .out_pay(ok_pos)
	);

	// offset to the image center and bound check
	logic signed [UW-1:0]    u_pos, v_pos, u_lim, v_lim;
	logic signed [DIM_W:0]   sw_m1, sh_m1;
	logic                    u_ok, v_ok, cfg_ok, inr;
	logic [OUT_W-1:0]        srcx_s9, srcy_s9;
	logic                    inr_s9;

	assign sw_m1  = $signed({1'b0, src_w_q}) - 14'sd1;
	assign sh_m1  = $signed({1'b0, src_h_q}) - 14'sd1;
	assign u_lim  = UW'($signed({sw_m1, 16'h0000}));
	assign v_lim  = UW'($signed({sh_m1, 16'h0000}));
	assign u_pos  = UW'(dx) + $signed(UW'({src_w_q, 15'h0000}));
	assign v_pos  = UW'(dy) + $signed(UW'({src_h_q, 15'h0000}));
	assign u_ok   = (u_pos >= 0) && (u_pos < u_lim) && (u_pos < CLIM);
	assign v_ok   = (v_pos >= 0) && (v_pos < v_lim) && (v_pos < CLIM);
	assign cfg_ok = (tgt_w_q != '0) && (tgt_h_q != '0) && (fov_q != '0);
	assign inr    = ok_pos && u_ok && v_ok && cfg_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s9 <= 1'b0;
		end else if (adv) begin
			valid_s9 <= pos_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			srcx_s9 <= inr ? u_pos[PIX_FRAC-FRAC_BITS +: OUT_W] : '0;
			srcy_s9 <= inr ? v_pos[PIX_FRAC-FRAC_BITS +: OUT_W] : '0;
			inr_s9  <= inr;
		end
	end

	assign m_tvalid = valid_s9;
	assign m_tdata  = OUT_TW'({srcy_s9, srcx_s9});
	assign m_tuser  = inr_s9;

	`E2F_ASSERT(a_stall_blocks_input, clk, arst_n, m_tvalid && !m_tready |-> !s_tready, "input taken while output stalled")
	`E2F_ASSERT(a_out_zero, clk, arst_n, m_tvalid && !m_tuser[0] |-> m_tdata == '0, "nonzero coordinate out of range")
	`E2F_ASSERT(a_valid_on_advance, clk, arst_n, $rose(m_tvalid) |-> $past(adv), "output valid rose without advance")

endmodule
